// File: rtl/core/wlsc_pkg.sv
// Shared types and constants for the wear-leveled seed counter.
`default_nettype none

package wlsc_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_W     = 32;
    localparam int SLOT_IDX_W = 3;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    typedef enum logic
    {
        OP_DRAW    = 1'b0,
        OP_PRELOAD = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage : wlsc_pkg

`default_nettype wire

// File: rtl/core/wlsc_ifs.sv
// Handshake interfaces for the request and response words.
`default_nettype none

interface wlsc_req_if;
    logic                              valid;
    logic                              ready;
    wlsc_pkg::op_t                     op;
    logic [wlsc_pkg::SLOT_IDX_W-1:0]   slot_index;
    logic [wlsc_pkg::WORD_W-1:0]       slot_value;

    modport source (output valid, op, slot_index, slot_value, input ready);
    modport sink   (input valid, op, slot_index, slot_value, output ready);
endinterface : wlsc_req_if

interface wlsc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [wlsc_pkg::WORD_W-1:0]       seed;
    logic [wlsc_pkg::SLOT_IDX_W-1:0]   written_slot;

    modport source (output valid, seed, written_slot, input ready);
    modport sink   (input valid, seed, written_slot, output ready);
endinterface : wlsc_rsp_if

`default_nettype wire

// File: rtl/core/wear_leveled_seed_counter_top.sv
// Wear-leveled seed counter: slot ring in memory, scan, write back one slot per draw.
`default_nettype none

// A preload word writes its slot directly; indices past the ring are dropped.
// A draw reads from 2 to SLOTS slots, until the run breaks: the slot memory
// has a single read port and is scanned one word per cycle from slot 0, then
// the chosen slot is written once. A new request is taken once the previous
// one has finished its write; a finished seed waits in the output register
// without holding off preloads. Slots read as all ones until first written,
// tracked by per-slot valid bits, so no clearing pass follows reset.
module wear_leveled_seed_counter_top
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    wlsc_req_if.sink    req,
    wlsc_rsp_if.source  rsp
);
    import wlsc_pkg::*;

    logic [WORD_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]  vld_reg;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] expect_reg, expect_next;
    logic [WORD_W-1:0] wr_val_reg, wr_val_next;
    logic [SLOT_W-1:0] wr_pos_reg, wr_pos_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [SLOT_IDX_W-1:0] slot_reg, slot_next;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] exp1;
    logic              accept;
    logic              preload_hit;
    logic              out_free;

    assign accept      = req.valid && req.ready;
    assign preload_hit = ({{(WORD_W-SLOT_IDX_W){1'b0}}, req.slot_index} < WORD_W'(SLOTS));
    assign cur         = rd_vld_reg ? rd_data_reg : '1;
    assign exp1        = expect_reg + WORD_W'(1);
    assign out_free    = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.op == OP_DRAW)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg != '0 && (cur != exp1 || cnt_reg == SLOT_LAST))
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req.ready      = (state_reg == ST_IDLE);
        cnt_next       = cnt_reg;
        expect_next    = expect_reg;
        wr_val_next    = wr_val_reg;
        wr_pos_next    = wr_pos_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        seed_next      = seed_reg;
        slot_next      = slot_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = SLOT_W'(req.slot_index);
        wr_data        = req.slot_value;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                rd_en    = 1'b1;
                if (accept && req.op == OP_PRELOAD && preload_hit)
                    wr_en = 1'b1;
            end
            ST_SCAN:
            begin
                rd_addr = cnt_reg + SLOT_W'(1);
                if (cnt_reg == '0)
                begin
                    expect_next = cur;
                    cnt_next    = cnt_reg + SLOT_W'(1);
                    rd_en       = 1'b1;
                end
                else if (cur != exp1)
                begin
                    wr_val_next = exp1;
                    wr_pos_next = cnt_reg;
                end
                else if (cnt_reg == SLOT_LAST)
                begin
                    wr_val_next = exp1 + WORD_W'(1);
                    wr_pos_next = '0;
                end
                else
                begin
                    expect_next = exp1;
                    cnt_next    = cnt_reg + SLOT_W'(1);
                    rd_en       = 1'b1;
                end
            end
            ST_WRITE:
            begin
                wr_addr = wr_pos_reg;
                wr_data = wr_val_reg;
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    out_valid_next = 1'b1;
                    seed_next      = wr_val_reg;
                    slot_next      = SLOT_IDX_W'(wr_pos_reg);
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.seed         = seed_reg;
    assign rsp.written_slot = slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        expect_reg <= expect_next;
        wr_val_reg <= wr_val_next;
        wr_pos_reg <= wr_pos_next;
        seed_reg   <= seed_next;
        slot_reg   <= slot_next;
    end

    // slot memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

endmodule : wear_leveled_seed_counter_top

`default_nettype wire

// File: rtl/core/wlsc_checker.sv
// Port-level checks for the seed counter, bound to the top level.
`default_nettype none

module wlsc_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire wlsc_pkg::op_t                     req_op,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [wlsc_pkg::WORD_W-1:0]       rsp_seed
);
    import wlsc_pkg::*;

    logic draw_acc;
    logic preload_acc;

    assign draw_acc    = req_valid && req_ready && req_op == OP_DRAW;
    assign preload_acc = req_valid && req_ready && req_op == OP_PRELOAD;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seed))
        else $error("stalled response word changed");

    a_preload_silent: assert property (@(posedge clk) disable iff (!rst_n)
        preload_acc && !rsp_valid |=> !rsp_valid)
        else $error("preload produced a response word");

    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        draw_acc |=> !req_ready)
        else $error("request taken while draw in progress");

    a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
        draw_acc && !rsp_valid |=> !rsp_valid)
        else $error("seed appeared before slot scan");

endmodule : wlsc_checker

bind wear_leveled_seed_counter_top wlsc_checker u_wlsc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (req.op),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_seed  (rsp.seed)
);

`default_nettype wire

// File: test/wear_leveled_seed_counter_top_tb.sv
// Testbench for the seed counter: random draws and preloads against a slot-ring predictor.
`timescale 1ns / 1ps

module wear_leveled_seed_counter_top_tb;

    import wlsc_pkg::*;

    localparam int HOLD_CYCLES = 500;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);

    typedef struct packed
    {
        logic [WORD_W-1:0]     seed;
        logic [SLOT_IDX_W-1:0] written_slot;
    } seed_word_t;

    class seed_ring_tracker;
        logic [WORD_W-1:0] ring [SLOTS];
        seed_word_t        expected_seeds [$];
        int                errors;

        function new();
            foreach (ring[i])
            begin
                ring[i] = '1;
            end
            errors = 0;
        endfunction

        function void note_word(op_t op, logic [SLOT_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            int unsigned       pos;
            logic [WORD_W-1:0] next_val;
            seed_word_t        w;
            if (op == OP_PRELOAD)
            begin
                if (idx < SLOTS)
                begin
                    ring[idx] = val;
                end
                return;
            end
            next_val = ring[0];
            pos = 0;
            for (int i = 1; i < SLOTS; i++)
            begin
                next_val = next_val + 1'b1;
                if (ring[i] != next_val)
                begin
                    pos = i;
                    break;
                end
            end
            if (pos == 0)
            begin
                next_val = next_val + 1'b1;
            end
            ring[pos] = next_val;
            w.seed = next_val;
            w.written_slot = SLOT_IDX_W'(pos);
            expected_seeds.push_back(w);
        endfunction

        function void check_seed(logic [WORD_W-1:0] seed, logic [SLOT_IDX_W-1:0] written_slot);
            seed_word_t w;
            if (expected_seeds.size() == 0)
            begin
                $display("%0t: unexpected seed word: seed %h slot %0d",
                         $time, seed, written_slot);
                errors++;
                return;
            end
            w = expected_seeds.pop_front();
            if (seed !== w.seed)
            begin
                $display("%0t: seed mismatch: expected %h actual %h", $time, w.seed, seed);
                errors++;
            end
            if (written_slot !== w.written_slot)
            begin
                $display("%0t: written_slot mismatch: expected %0d actual %0d",
                         $time, w.written_slot, written_slot);
                errors++;
            end
        endfunction

        function int pending();
            return expected_seeds.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wlsc_req_if req();
    wlsc_rsp_if rsp();

    wear_leveled_seed_counter_top i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    seed_ring_tracker tracker = new();

    bit tx_idles;
    bit rx_stalls;
    int idle_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int sent_count;
    int quiet_cycles;

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= !(rx_stalls && $urandom_range(99) < idle_pct);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                tracker.note_word(req.op, req.slot_index, req.slot_value);
            end
            if (rsp.valid && rsp.ready)
            begin
                tracker.check_seed(rsp.seed, rsp.written_slot);
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("wear_leveled_seed_counter_top_tb failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_word(op_t op, logic [SLOT_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        while (tx_idles && $urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.op         <= op;
        req.slot_index <= idx;
        req.slot_value <= val;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    task automatic draw_seed();
        send_word(OP_DRAW, SLOT_IDX_W'($urandom), $urandom);
    endtask

    task automatic preload_slot(int idx, logic [WORD_W-1:0] val);
        send_word(OP_PRELOAD, SLOT_IDX_W'(idx), val);
    endtask

    // consecutive run from slot 0, optionally broken, then some draws
    task automatic run_sequence();
        int                len;
        int                draws;
        logic [WORD_W-1:0] base;
        len = $urandom_range(SLOTS);
        draws = $urandom_range(1, 4);
        base = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF - $urandom_range(10) : $urandom;
        for (int i = 0; i < len; i++)
        begin
            preload_slot(i, base + i);
        end
        if (len < SLOTS && $urandom_range(1))
        begin
            preload_slot(len, $urandom);
        end
        repeat (draws)
        begin
            draw_seed();
        end
    endtask

    task automatic run_phase(int budget);
        int stop_at;
        int pick;
        stop_at = sent_count + budget;
        while (sent_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                run_sequence();
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    draw_seed();
                end
            end
            else
            begin
                send_word(OP_PRELOAD, SLOT_IDX_W'($urandom), $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.op = OP_DRAW;
        req.slot_index = '0;
        req.slot_value = '0;
        rsp.ready = 1'b0;
        tx_idles = 1'b0;
        rx_stalls = 1'b0;
        idle_pct = 62;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        sent_count = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // erased ring, then a full run that wraps on the final increment
        draw_seed();
        draw_seed();
        for (int i = 0; i < SLOTS; i++)
        begin
            preload_slot(i, 32'hFFFF_FFF8 + i);
        end
        draw_seed();
        draw_seed();
        send_word(OP_PRELOAD, SLOT_IDX_W'(3), 32'h0000_0000);
        send_word(OP_PRELOAD, SLOT_IDX_W'(6), 32'hFFFF_FFFF);
        send_word(OP_DRAW, SLOT_IDX_W'(7), 32'hFFFF_FFFF);
        send_word(OP_DRAW, SLOT_IDX_W'(0), 32'h0000_0000);

        run_phase(170);

        tx_idles = 1'b1;
        run_phase(170);

        tx_idles = 1'b0;
        rx_stalls <= 1'b1;
        run_phase(170);

        tx_idles = 1'b1;
        rx_stalls <= 1'b1;
        idle_pct = 28;
        run_phase(130);

        tx_idles = 1'b0;
        rx_stalls <= 1'b0;
        idle_pct = 62;
        hold_req <= hold_req + 1;
        run_phase(40);

        rx_stalls <= 1'b1;
        run_phase(60);

        req.valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("wear_leveled_seed_counter_top_tb passed");
        end
        else
        begin
            $display("wear_leveled_seed_counter_top_tb failed");
        end
        $finish;
    end

endmodule : wear_leveled_seed_counter_top_tb
